/* sv/mu7u8_pkg.sv */
// ----------------------------------------------------------------------------
// mu7u8_pkg
// Shared types and constants for the modified UTF-7 to UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mu7u8_pkg;

    localparam int RUN_BYTES   = 4;
    localparam int QUEUE_DEPTH = 2;

    // ASCII codes that steer the decoder
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;

    // One decoded run: up to four UTF-8 bytes, last_idx marks the final one
    typedef struct packed {
        logic [RUN_BYTES-1:0][7:0] bytes;
        logic [1:0]                last_idx;
    } mu7u8_run_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } mu7u8_digit_t;

endpackage

`default_nettype wire

/* sv/modified_utf7_to_utf8_decoder.sv */
// ----------------------------------------------------------------------------
// modified_utf7_to_utf8_decoder
// IMAP modified UTF-7 mailbox-name bytes in, UTF-8 bytes out.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+-----------------------
//  in      | in_valid in_stall in_byte in_last| sink      | one encoded byte
//  out     | out_valid out_stall out_byte     | source    | one UTF-8 byte,
//          | out_last                         |           | out_last ends a run
//
//  Rates: the front decodes one byte per cycle unless in_stall holds it; the
//  back emits one UTF-8 byte per cycle unless out_stall holds it. A literal
//  yields one UTF-8 byte, a decoded code point up to four.
//  The first output beat passes through a queue entry and then the back's
//  run register before out_valid shows it.
//  Reset: asynchronous, clears decode mode, bit buffer, count and code point.
//  Stalls: in_stall rises only when the two-run queue is full; out_stall holds
//  the current output beat and lets the front keep going until the queue fills.
//
`default_nettype none

module modified_utf7_to_utf8_decoder
    import mu7u8_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    mu7u8_run_t front_run;
    mu7u8_run_t head;
    logic       run_push;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    logic       take;

    // input beat accepted whenever the queue has room for a run
    assign in_stall = q_full;
    assign take     = in_valid && !in_stall;

    mu7u8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .run      (front_run),
        .run_push (run_push)
    );

    mu7u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (run_push),
        .push_run (front_run),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    mu7u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

/* sv/mu7u8_front.sv */
// ----------------------------------------------------------------------------
// mu7u8_front
// Per-byte decode: escape and base64 state, surrogate joining, UTF-8 encode.
// ----------------------------------------------------------------------------
`default_nettype none

module mu7u8_front
    import mu7u8_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output mu7u8_run_t      run,
    output logic            run_push
);

    typedef enum logic [1:0] {
        MODE_LIT = 2'd0,
        MODE_ESC = 2'd1,
        MODE_B64 = 2'd2
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic [21:0]  buf_reg, buf_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic [31:0]  cp_reg, cp_next;

    logic [21:0]  base_buf;
    logic [4:0]   base_cnt;
    logic [31:0]  base_cp;
    mu7u8_digit_t dig;
    logic [21:0]  sec_buf;
    logic [21:0]  sec_shift;
    logic [4:0]   sec_cnt6;
    logic [4:0]   sec_cnt;
    logic         sec_full;
    logic [15:0]  unit;
    logic         unit_hi;
    logic         unit_lo;
    logic [31:0]  sec_cp;
    logic [31:0]  enc_bytes;
    logic [2:0]   enc_n;
    logic [2:0]   n;

    function automatic mu7u8_digit_t b64_decode(input logic [7:0] c);
        mu7u8_digit_t d;
        logic [7:0]   t;
        d = '0;
        t = '0;
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            t = c - CH_UC_A;
            d = '{valid: 1'b1, value: t[5:0]};
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            t = c - CH_LC_A + 8'd26;
            d = '{valid: 1'b1, value: t[5:0]};
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            t = c - CH_DIG_0 + 8'd52;
            d = '{valid: 1'b1, value: t[5:0]};
        end else if (c == CH_PLUS) begin
            d = '{valid: 1'b1, value: 6'd62};
        end else if (c == CH_COMMA) begin
            d = '{valid: 1'b1, value: 6'd63};
        end
        return d;
    endfunction

    // section state seen by this byte: an opening escape starts from zero
    assign base_buf = (mode_reg == MODE_ESC) ? '0 : buf_reg;
    assign base_cnt = (mode_reg == MODE_ESC) ? '0 : cnt_reg;
    assign base_cp  = (mode_reg == MODE_ESC) ? '0 : cp_reg;

    assign dig       = b64_decode(in_byte);
    assign sec_buf   = {base_buf[15:0], dig.value};
    assign sec_cnt6  = base_cnt + 5'd6;
    assign sec_full  = (sec_cnt6 >= 5'd16);
    assign sec_cnt   = sec_cnt6 - 5'd16;
    assign sec_shift = sec_buf >> sec_cnt;
    assign unit      = sec_shift[15:0];
    assign unit_hi   = (unit[15:10] == 6'b110110);
    assign unit_lo   = (unit[15:10] == 6'b110111);

    always_comb
    begin
        if (unit_lo)
            sec_cp = base_cp + {22'd0, unit[9:0]} + 32'h0001_0000;
        else
            sec_cp = {16'd0, unit};
    end

    // UTF-8 encode of the new code point; byte 0 leads
    always_comb
    begin
        enc_bytes = '0;
        if (sec_cp <= 32'h7F) begin
            enc_bytes[7:0] = sec_cp[7:0];
            enc_n          = 3'd1;
        end else if (sec_cp <= 32'h7FF) begin
            enc_bytes[7:0]  = {3'b110, sec_cp[10:6]};
            enc_bytes[15:8] = {2'b10, sec_cp[5:0]};
            enc_n           = 3'd2;
        end else if (sec_cp <= 32'hFFFF) begin
            enc_bytes[7:0]   = {4'b1110, sec_cp[15:12]};
            enc_bytes[15:8]  = {2'b10, sec_cp[11:6]};
            enc_bytes[23:16] = {2'b10, sec_cp[5:0]};
            enc_n            = 3'd3;
        end else begin
            enc_bytes[7:0]   = 8'hF0 | sec_cp[25:18];
            enc_bytes[15:8]  = {2'b10, sec_cp[17:12]};
            enc_bytes[23:16] = {2'b10, sec_cp[11:6]};
            enc_bytes[31:24] = {2'b10, sec_cp[5:0]};
            enc_n            = 3'd4;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        cp_next   = cp_reg;
        run.bytes = '0;
        n         = 3'd0;

        if (mode_reg == MODE_ESC && in_byte == CH_DASH) begin
            mode_next    = MODE_LIT;
            run.bytes[0] = CH_AMP;
            n            = 3'd1;
        end else if (mode_reg == MODE_ESC || mode_reg == MODE_B64) begin
            buf_next = base_buf;
            cnt_next = base_cnt;
            cp_next  = base_cp;
            if (!dig.valid) begin
                // section ends; '-' dropped, anything else taken as literal
                if (in_byte == CH_AMP) begin
                    mode_next = MODE_ESC;
                end else begin
                    mode_next = MODE_LIT;
                    if (in_byte != CH_DASH) begin
                        run.bytes[0] = in_byte;
                        n            = 3'd1;
                    end
                end
            end else begin
                mode_next = MODE_B64;
                buf_next  = sec_buf;
                if (!sec_full) begin
                    cnt_next = sec_cnt6;
                end else begin
                    cnt_next = sec_cnt;
                    if (unit_hi) begin
                        cp_next = {12'd0, unit[9:0], 10'd0};
                    end else begin
                        cp_next   = sec_cp;
                        run.bytes = enc_bytes;
                        n         = enc_n;
                    end
                end
            end
        end else begin
            if (in_byte == CH_AMP) begin
                mode_next = MODE_ESC;
            end else begin
                mode_next    = MODE_LIT;
                run.bytes[0] = in_byte;
                n            = 3'd1;
            end
        end

        if (in_last) begin
            mode_next = MODE_LIT;
            buf_next  = '0;
            cnt_next  = '0;
            cp_next   = '0;
        end

        run.last_idx = 2'(n - 3'd1);
    end

    assign run_push = take && (n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_LIT;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            cp_reg   <= '0;
        end else if (take) begin
            mode_reg <= mode_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            cp_reg   <= cp_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mu7u8_queue.sv */
// ----------------------------------------------------------------------------
// mu7u8_queue
// Short FIFO of decoded runs between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mu7u8_queue
    import mu7u8_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire mu7u8_run_t push_run,
    input  wire logic       pop,
    output mu7u8_run_t      head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mu7u8_run_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_run;
    end

endmodule

`default_nettype wire

/* sv/mu7u8_back.sv */
// ----------------------------------------------------------------------------
// mu7u8_back
// Serializes one queued run into output beats, marking the run's last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mu7u8_back
    import mu7u8_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mu7u8_run_t head,
    input  wire logic       empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic       busy_reg, busy_next;
    mu7u8_run_t run_reg, run_next;
    logic [1:0] idx_reg, idx_next;
    logic       beat;
    logic       at_end;

    assign beat      = busy_reg && !out_stall;
    assign at_end    = (idx_reg == run_reg.last_idx);
    assign out_valid = busy_reg;
    assign out_byte  = run_reg.bytes[idx_reg];
    assign out_last  = at_end;

    // load the next run when idle or as the current one finishes
    assign pop = !empty && (!busy_reg || (beat && at_end));

    always_comb
    begin
        busy_next = busy_reg;
        run_next  = run_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            run_next  = head;
            idx_next  = '0;
        end else if (beat) begin
            if (at_end)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

endmodule

`default_nettype wire

/* tb/sv/modified_utf7_to_utf8_decoder_tb.sv */
// ----------------------------------------------------------------------------
// modified_utf7_to_utf8_decoder_tb
// Self-checking bench: encoded mailbox-name bytes in, UTF-8 beats checked out.
// A behavioral decoder tracks mode, bit buffer and code point for every
// accepted byte and queues the UTF-8 beats it should produce. Directed names
// cover the escapes, section closers, surrogates and the last flag. Random
// names follow, under three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------

module modified_utf7_to_utf8_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mu7u8_pkg::*;

    localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
    localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
    // no closing byte: the final base64 digit carries the last flag instead
    localparam logic [7:0]  NO_CLOSER     = 8'h00;
    localparam int          TAIL_CYCLES   = 16;
    localparam int          WATCHDOG_NS   = 10_000_000;

    typedef enum logic [1:0] {
        MODE_LITERAL   = 2'd0,
        MODE_AFTER_AMP = 2'd1,
        MODE_BASE64    = 2'd2
    } dec_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_beat_t;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    modified_utf7_to_utf8_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    utf8_beat_t  utf8_expect[$];     // beats still owed by the DUT, oldest first
    logic [15:0] utf16_units[$];     // units for the next base64 section
    utf8_beat_t  head_beat;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int bytes_sent      = 0;
    int beats_checked   = 0;
    int sections_opened = 0;
    int names_ended     = 0;
    int fail_count      = 0;

    // predictor copy of the decoder state
    dec_mode_e   dec_mode = MODE_LITERAL;
    logic [21:0] bit_buf  = '0;
    logic [4:0]  bit_cnt  = '0;
    logic [31:0] cur_cp   = '0;

    // ------------------------------------------------------------------
    // Base64 alphabet (',' stands where standard base64 has '/')
    // ------------------------------------------------------------------
    function automatic int b64_value(input logic [7:0] c);
        if (c >= CH_UC_A && c <= CH_UC_Z)
            return int'(c - CH_UC_A);
        if (c >= CH_LC_A && c <= CH_LC_Z)
            return int'(c - CH_LC_A) + 26;
        if (c >= CH_DIG_0 && c <= CH_DIG_9)
            return int'(c - CH_DIG_0) + 52;
        if (c == CH_PLUS)
            return 62;
        if (c == CH_COMMA)
            return 63;
        return -1;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26)
            return CH_UC_A + {2'b00, v};
        if (v < 6'd52)
            return CH_LC_A + {2'b00, v - 6'd26};
        if (v < 6'd62)
            return CH_DIG_0 + {2'b00, v - 6'd52};
        if (v == 6'd62)
            return CH_PLUS;
        return CH_COMMA;
    endfunction

    // UTF-8 bytes of one code point; beyond 0xFFFF always four bytes, and
    // bits above 18 spill into the lead byte (cut to 8 bits).
    function automatic int utf8_encode(input logic [31:0] cp, output logic [3:0][7:0] b);
        b = '0;
        if (cp <= 32'h7F) begin
            b[0] = cp[7:0];
            return 1;
        end
        if (cp <= 32'h7FF) begin
            b[0] = 8'hC0 | cp[13:6];
            b[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp <= 32'hFFFF) begin
            b[0] = 8'hE0 | cp[19:12];
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            return 3;
        end
        b[0] = 8'hF0 | cp[25:18];
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // ------------------------------------------------------------------
    // Decoder model: one accepted byte in, owed UTF-8 beats queued
    // ------------------------------------------------------------------
    task automatic decode_byte(input logic [7:0] c, input logic last);
        logic [3:0][7:0] run;
        logic [15:0]     unit;
        logic            as_literal;
        logic            in_section;
        utf8_beat_t      beat;
        int              n;
        int              v;
        int              k;
        run        = '0;
        unit       = '0;
        as_literal = 1'b0;
        in_section = 1'b0;
        n          = 0;

        case (dec_mode)
            MODE_AFTER_AMP: begin
                if (c == CH_DASH) begin
                    // "&-" is an escaped ampersand
                    dec_mode = MODE_LITERAL;
                    run[0]   = CH_AMP;
                    n        = 1;
                end else begin
                    // section opens: gathered bits and code point start clean
                    dec_mode   = MODE_BASE64;
                    bit_buf    = '0;
                    bit_cnt    = '0;
                    cur_cp     = '0;
                    in_section = 1'b1;
                end
            end
            MODE_BASE64: in_section = 1'b1;
            default:     as_literal = 1'b1;
        endcase

        if (in_section) begin
            v = b64_value(c);
            if (v < 0) begin
                // any non-alphabet byte ends the section, leftover bits dropped;
                // '-' is swallowed, anything else goes on as a literal
                dec_mode   = MODE_LITERAL;
                as_literal = (c != CH_DASH);
            end else begin
                bit_buf = {bit_buf[15:0], v[5:0]};
                bit_cnt = bit_cnt + 5'd6;
                if (bit_cnt >= 5'd16) begin
                    bit_cnt = bit_cnt - 5'd16;
                    unit    = 16'(bit_buf >> bit_cnt);
                    if (unit >= HI_SURR_FIRST && unit <= HI_SURR_LAST) begin
                        // high surrogate: hold it, nothing leaves yet
                        cur_cp = ({16'h0000, unit} - {16'h0000, HI_SURR_FIRST}) << 10;
                    end else begin
                        if (unit >= LO_SURR_FIRST && unit <= LO_SURR_LAST)
                            // low surrogate adds onto whatever is held, paired or not
                            cur_cp = cur_cp + {16'h0000, unit} - {16'h0000, LO_SURR_FIRST}
                                     + 32'h0001_0000;
                        else
                            cur_cp = {16'h0000, unit};
                        n = utf8_encode(cur_cp, run);
                    end
                end
            end
        end

        if (as_literal) begin
            if (c == CH_AMP) begin
                dec_mode = MODE_AFTER_AMP;
            end else begin
                dec_mode = MODE_LITERAL;
                run[0]   = c;
                n        = 1;
            end
        end

        for (k = 0; k < n; k++) begin
            beat.data = run[k];
            beat.last = (k == n - 1);
            utf8_expect.push_back(beat);
        end

        if (last) begin
            dec_mode = MODE_LITERAL;
            bit_buf  = '0;
            bit_cnt  = '0;
            cur_cp   = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: one beat per call. in_valid is left high after acceptance;
    // the next call either drops it for an idle gap or presents the next byte.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(c, last);
        bytes_sent++;
        if (last)
            names_ended++;
    endtask

    task automatic send_text(input string s, input logic last_on_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], last_on_end && (i == s.len() - 1));
    endtask

    // '&', then utf16_units as base64 digits (zero-padded), then the closer.
    // With NO_CLOSER the final byte of the section carries the last flag.
    task automatic send_section(input logic [7:0] closer, input logic closer_last);
        logic [7:0]  digits[$];
        logic [31:0] acc;
        int          nbits;
        int          k;
        acc   = '0;
        nbits = 0;
        for (k = 0; k < utf16_units.size(); k++) begin
            acc   = (acc << 16) | {16'h0000, utf16_units[k]};
            nbits = nbits + 16;
            while (nbits >= 6) begin
                nbits = nbits - 6;
                digits.push_back(b64_char(6'(acc >> nbits)));
            end
        end
        if (nbits > 0)
            digits.push_back(b64_char(6'(acc << (6 - nbits))));

        sections_opened++;
        send_byte(CH_AMP, (closer == NO_CLOSER) && (digits.size() == 0));
        for (k = 0; k < digits.size(); k++)
            send_byte(digits[k], (closer == NO_CLOSER) && (k == digits.size() - 1));
        if (closer != NO_CLOSER)
            send_byte(closer, closer_last);
    endtask

    // Hold the input off until every owed beat has come back, then let the
    // pipeline run dry so a stray extra beat would still be caught.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (utf8_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic push_random_unit();
        case ($urandom_range(7))
            0: utf16_units.push_back(16'($urandom_range(16'h007F)));
            1: utf16_units.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
            2: begin
                if ($urandom_range(1))
                    utf16_units.push_back(16'($urandom_range(16'hD7FF, 16'h0800)));
                else
                    utf16_units.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
            end
            3, 4, 5: begin
                // well-formed surrogate pair
                utf16_units.push_back(16'($urandom_range(HI_SURR_LAST, HI_SURR_FIRST)));
                utf16_units.push_back(16'($urandom_range(LO_SURR_LAST, LO_SURR_FIRST)));
            end
            6: utf16_units.push_back(16'($urandom_range(LO_SURR_LAST, LO_SURR_FIRST)));
            default: utf16_units.push_back(16'($urandom_range(HI_SURR_LAST, HI_SURR_FIRST)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_literal_bytes();
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // a dash outside a section is just a character
        send_text("Inbox-", 1'b1);
    endtask

    task automatic test_ampersand_escapes();
        send_text("&-", 1'b0);
        send_text("a&-", 1'b1);
        // '&' as the final byte of a name produces nothing
        send_byte(CH_AMP, 1'b1);
        send_text("x", 1'b0);
        // '&' then a non-alphabet byte: empty section, byte passes through
        send_text("&.", 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(8'hFF, 1'b0);
        // second '&' closes the empty section and starts a fresh escape
        send_text("&&-", 1'b0);
    endtask

    task automatic test_bmp_and_surrogates();
        // one-, two- and three-byte UTF-8 lengths at their boundaries, around the surrogate gap
        utf16_units = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                        16'hD7FF, 16'hE000, 16'hFFFF};
        send_section(CH_DASH, 1'b0);
        // pairs: lowest, highest, and a typical one
        utf16_units = '{16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hD83D, 16'hDE00};
        send_section(CH_DASH, 1'b0);
        // unpaired low surrogate right after the section opens
        utf16_units = '{16'hDC00};
        send_section(CH_DASH, 1'b0);
        // lone high surrogate is overwritten by the next plain unit
        utf16_units = '{16'hDBFF, 16'h0041};
        send_section(CH_DASH, 1'b0);
        // low surrogate adds onto a plain code point still held
        utf16_units = '{16'h0041, 16'hDC05};
        send_section(CH_DASH, 1'b1);
    endtask

    task automatic test_section_closers();
        utf16_units = '{16'h00E9};
        send_section(8'h2E, 1'b0);
        // closing '&' opens a new escape; the dash makes it a plain '&'
        utf16_units = '{16'h20AC};
        send_section(CH_AMP, 1'b0);
        send_byte(CH_DASH, 1'b0);
        utf16_units = '{16'h0041};
        send_section(8'h80, 1'b0);
        // section cut short by the last flag on its final digit
        utf16_units = '{16'h0041, 16'h0042};
        send_section(NO_CLOSER, 1'b0);
        send_text("z", 1'b0);
    endtask

    task automatic test_last_flag();
        // last flag mid-section with leftover bits; next name starts literal
        send_text("&2D3", 1'b1);
        send_text("AB", 1'b0);
        send_text("&AE", 1'b1);
        send_text("-", 1'b0);
    endtask

    task automatic test_oversized_code_point();
        int k;
        // a long run of unpaired low surrogates keeps adding onto the code
        // point until it passes 21 bits and the lead byte grows past 0xF7
        utf16_units.delete();
        for (k = 0; k < 32; k++)
            utf16_units.push_back(LO_SURR_LAST);
        send_section(CH_DASH, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random names: base64 sections with random units (the largest share), plus
    // literal runs, escaped ampersands and some raw noise.
    // ------------------------------------------------------------------
    task automatic test_random_names(input int target, input int send_pct, input int recv_pct);
        int          start_count;
        int          len;
        int          k;
        logic [7:0]  c;
        logic [7:0]  closer;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < target) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(6, 1);
                    for (k = 0; k < len; k++) begin
                        c = 8'($urandom_range(255, 1));
                        while (c == CH_AMP)
                            c = 8'($urandom_range(255, 1));
                        send_byte(c, (k == len - 1) && ($urandom_range(3) == 0));
                    end
                end
                6, 7: send_text("&-", $urandom_range(4) == 0);
                8, 9, 10, 11, 12, 13, 14, 15, 16: begin
                    utf16_units.delete();
                    len = $urandom_range(4, 1);
                    for (k = 0; k < len; k++)
                        push_random_unit();
                    case ($urandom_range(9))
                        7:       closer = NO_CLOSER;
                        8:       closer = CH_AMP;
                        9: begin
                            closer = 8'($urandom_range(255, 1));
                            while (b64_value(closer) >= 0)
                                closer = 8'($urandom_range(255, 1));
                        end
                        default: closer = CH_DASH;
                    endcase
                    send_section(closer, $urandom_range(5) == 0);
                end
                default: begin
                    // noise biased toward the bytes that steer the decoder
                    len = $urandom_range(8, 1);
                    for (k = 0; k < len; k++) begin
                        case ($urandom_range(3))
                            0:       c = b64_char(6'($urandom_range(63)));
                            1:       c = CH_AMP;
                            2:       c = CH_DASH;
                            default: c = 8'($urandom_range(255, 1));
                        endcase
                        send_byte(c, $urandom_range(9) == 0);
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, and a check of every accepted beat
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            beats_checked++;
            if (utf8_expect.size() == 0) begin
                $error("unexpected beat: out_byte %02h out_last %0b", out_byte, out_last);
                fail_count++;
            end else begin
                head_beat = utf8_expect.pop_front();
                if (out_byte !== head_beat.data) begin
                    $error("out_byte: expected %02h, got %02h", head_beat.data, out_byte);
                    fail_count++;
                end
                if (out_last !== head_beat.last) begin
                    $error("out_last: expected %0b, got %0b", head_beat.last, out_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 46;
        test_literal_bytes();
        test_ampersand_escapes();
        test_bmp_and_surrogates();
        test_section_closers();
        test_last_flag();
        test_oversized_code_point();
        drain_results();

        // sender pauses for a full drain between idle mixes
        test_random_names(50, 13, 46);
        drain_results();
        test_random_names(50, 46, 13);
        drain_results();
        test_random_names(50, 0, 0);
        drain_results();

        $display("sent %0d encoded bytes in %0d sections, %0d names closed by last flag",
                 bytes_sent, sections_opened, names_ended);
        $display("checked %0d UTF-8 beats under three sender/receiver idle mixes",
                 beats_checked);
        if (fail_count == 0)
            $display("modified_utf7_to_utf8_decoder: match");
        else
            $display("modified_utf7_to_utf8_decoder: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("modified_utf7_to_utf8_decoder: mismatch");
        $finish;
    end

endmodule
